### hdl/assert_macros.svh
// Assertion macros for the checker module of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("frame receiver check failed");

// Concurrent check that also holds while reset is asserted.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("frame receiver check failed");

`endif

### hdl/fsfr_pkg.sv
// Package with the frame constants, parser phases and result type.
`default_nettype none

package fsfr_pkg;

  // Frame layout.
  localparam logic [7:0]  HdrFirst  = 8'hFE;
  localparam logic [7:0]  HdrSecond = 8'h0A;
  localparam int unsigned FrameLen  = 14;
  localparam int unsigned FirstData = 2;
  localparam int unsigned CheckPos  = 12;
  localparam int unsigned LastPos   = FrameLen - 1;
  localparam int unsigned IdxW      = $clog2(FrameLen);

  // Parser phases: hunting for the first header byte, expecting the
  // second one, and collecting the frame body.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SYNC,
    PH_DATA
  } phase_e;

  // One decoded frame.
  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] flow_x_sum;
    logic [15:0] flow_y_sum;
    logic [15:0] span_us;
    logic [15:0] ground_dist;
    logic [7:0]  quality;
    logic [7:0]  version_byte;
  } fsfr_result_t;

endpackage

`default_nettype wire

### hdl/flow_sensor_frame_receiver_core.sv
// Top level of the optical-flow sensor frame receiver.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------------------
//  input   | in_valid_i / in_ready_o | rx_byte_i
//  output  | out_valid_o/out_ready_i | checksum_ok_o .. version_byte_o
//
// A byte enters every cycle unless a waiting result holds input off.
// A frame result enters the result register when the parser takes its last byte.
// Reset returns the parser to header hunting and empties both registers.
// A waiting result holds off only a byte that ends a frame; that byte stays
// in the input register and input resumes as soon as the result is taken.
`default_nettype none

module flow_sensor_frame_receiver_core
  import fsfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             checksum_ok_o,
  output logic [15:0]      flow_x_sum_o,
  output logic [15:0]      flow_y_sum_o,
  output logic [15:0]      span_us_o,
  output logic [15:0]      ground_dist_o,
  output logic [7:0]       quality_o,
  output logic [7:0]       version_byte_o
);

  logic         byte_vld;
  logic [7:0]   byte_q;
  logic         step;
  logic         res_vld;
  logic         out_free;
  fsfr_result_t res;
  fsfr_result_t res_out;

  // A held byte is parsed unless it ends a frame while the result register
  // is still occupied.
  assign step = byte_vld && (out_free || !res_vld);

  fsfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .byte_vld_o (byte_vld),
    .byte_o     (byte_q)
  );

  fsfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  fsfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_vld),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .res_o       (res_out)
  );

  // Result fields onto their ports.
  assign checksum_ok_o  = res_out.checksum_ok;
  assign flow_x_sum_o   = res_out.flow_x_sum;
  assign flow_y_sum_o   = res_out.flow_y_sum;
  assign span_us_o      = res_out.span_us;
  assign ground_dist_o  = res_out.ground_dist;
  assign quality_o      = res_out.quality;
  assign version_byte_o = res_out.version_byte;

endmodule

`default_nettype wire

### hdl/fsfr_in_reg.sv
// Input register stage that holds one received byte until the parser takes it.
`default_nettype none

module fsfr_in_reg
  import fsfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            byte_vld_o,
  output logic [7:0]      byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  // The stage can load when empty or when its byte leaves this cycle.
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = (vld_q && !take_i) || in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= vld_d;
    end
  end

  // Payload register, loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_vld_o = vld_q;
  assign byte_o     = byte_q;

endmodule

`default_nettype wire

### hdl/fsfr_parser.sv
// Frame parser: header sync, byte index, running XOR and frame byte store.
`default_nettype none

module fsfr_parser
  import fsfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   step_i,
  input  wire logic [7:0] byte_i,
  output logic        res_vld_o,
  output fsfr_result_t res_o
);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      xor_q, xor_d;
  logic            store_en;
  logic [7:0]      data_q [FirstData:CheckPos];

  // Next phase, byte index and running XOR.
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    xor_d   = xor_q;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i == HdrFirst) begin
          phase_d = PH_SYNC;
        end
      end
      PH_SYNC: begin
        // A wrong second byte is dropped, even a repeated first header byte.
        if (byte_i == HdrSecond) begin
          phase_d = PH_DATA;
          idx_d   = IdxW'(FirstData);
          xor_d   = 8'h00;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (idx_q < IdxW'(CheckPos)) begin
          xor_d = xor_q ^ byte_i;
        end
        if (idx_q == IdxW'(LastPos)) begin
          phase_d = PH_IDLE;
          xor_d   = 8'h00;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
        xor_d   = 8'h00;
      end
    endcase
  end

  // Outputs of the phase logic: byte store enable and frame end.
  always_comb begin
    store_en  = 1'b0;
    res_vld_o = 1'b0;
    case (phase_q)
      PH_DATA: begin
        store_en  = 1'b1;
        res_vld_o = (idx_q == IdxW'(LastPos));
      end
      default: begin
        store_en  = 1'b0;
        res_vld_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      xor_q   <= 8'h00;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
    end
  end

  // Frame bytes 2 to 12; the trailing byte is never read, so it is not kept.
  always_ff @(posedge clk_i) begin
    for (int i = FirstData; i <= CheckPos; i++) begin
      if (step_i && store_en && idx_q == IdxW'(i)) begin
        data_q[i] <= byte_i;
      end
    end
  end

  // Result fields, little-endian pairs straight from the byte store.
  always_comb begin
    res_o.checksum_ok  = (xor_q == data_q[CheckPos]);
    res_o.flow_x_sum   = {data_q[3], data_q[2]};
    res_o.flow_y_sum   = {data_q[5], data_q[4]};
    res_o.span_us      = {data_q[7], data_q[6]};
    res_o.ground_dist  = {data_q[9], data_q[8]};
    res_o.quality      = data_q[10];
    res_o.version_byte = data_q[11];
  end

endmodule

`default_nettype wire

### hdl/fsfr_out_reg.sv
// Result register that holds one decoded frame until it is taken.
`default_nettype none

module fsfr_out_reg
  import fsfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire fsfr_result_t res_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic        free_o,
  output fsfr_result_t res_o
);

  logic         vld_q, vld_d;
  fsfr_result_t res_q;

  // The register is free when empty or when its result is taken now.
  assign free_o = !vld_q || out_ready_i;
  assign vld_d  = (vld_q && !out_ready_i) || load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### hdl/fsfr_checker.sv
// Port-level checker for the frame receiver and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module fsfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        checksum_ok_o,
  input wire logic [15:0] flow_x_sum_o,
  input wire logic [15:0] flow_y_sum_o,
  input wire logic [15:0] span_us_o,
  input wire logic [15:0] ground_dist_o,
  input wire logic [7:0]  quality_o,
  input wire logic [7:0]  version_byte_o
);

  // No result is offered while reset is asserted.
  `ASSERT_CLK(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // With the result register empty, input is never held off.
  `ASSERT_CLK_RST(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // An offered result stays until it is taken.
  `ASSERT_CLK_RST(a_result_held, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o)

  // A stalled result keeps its fields.
  `ASSERT_CLK_RST(a_result_stable, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> $stable({checksum_ok_o, flow_x_sum_o,
      flow_y_sum_o, span_us_o, ground_dist_o, quality_o, version_byte_o}))

endmodule

bind flow_sensor_frame_receiver_core fsfr_checker u_fsfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .checksum_ok_o  (checksum_ok_o),
  .flow_x_sum_o   (flow_x_sum_o),
  .flow_y_sum_o   (flow_y_sum_o),
  .span_us_o      (span_us_o),
  .ground_dist_o  (ground_dist_o),
  .quality_o      (quality_o),
  .version_byte_o (version_byte_o)
);

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the optical-flow sensor frame receiver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsfr_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned BodyLen     = CheckPos - FirstData;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b1;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  rx_byte_i      = 8'h00;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        checksum_ok_o;
  logic [15:0] flow_x_sum_o;
  logic [15:0] flow_y_sum_o;
  logic [15:0] span_us_o;
  logic [15:0] ground_dist_o;
  logic [7:0]  quality_o;
  logic [7:0]  version_byte_o;

  // Idle and stall rates in percent, and the long receiver hold-off.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_on           = 1'b0;
  int unsigned quiet_cycles      = 0;
  int unsigned mismatch_count    = 0;

  // Parser state mirrored by the predictor.
  phase_e       rx_phase = PH_IDLE;
  int unsigned  rx_pos   = 0;
  logic [7:0]   body_xor = 8'h00;
  logic [7:0]   frame_bytes [FrameLen];
  fsfr_result_t frames_due [$];

  flow_sensor_frame_receiver_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .checksum_ok_o  (checksum_ok_o),
    .flow_x_sum_o   (flow_x_sum_o),
    .flow_y_sum_o   (flow_y_sum_o),
    .span_us_o      (span_us_o),
    .ground_dist_o  (ground_dist_o),
    .quality_o      (quality_o),
    .version_byte_o (version_byte_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Advances the predicted parser by one accepted byte and queues the frame
  // result when the last byte of a frame arrives.
  task automatic parse_rx_byte(input logic [7:0] value);
    fsfr_result_t frame;
    case (rx_phase)
      PH_IDLE: begin
        if (value == HdrFirst) begin
          frame_bytes[0] = value;
          rx_phase = PH_SYNC;
        end
      end
      PH_SYNC: begin
        // A second header start does not resync; anything but 0x0A drops out.
        if (value == HdrSecond) begin
          frame_bytes[1] = value;
          rx_pos   = FirstData;
          body_xor = 8'h00;
          rx_phase = PH_DATA;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_DATA: begin
        frame_bytes[rx_pos] = value;
        if (rx_pos < CheckPos) body_xor = body_xor ^ value;
        if (rx_pos == LastPos) begin
          frame.checksum_ok  = (body_xor == frame_bytes[CheckPos]);
          frame.flow_x_sum   = {frame_bytes[3], frame_bytes[2]};
          frame.flow_y_sum   = {frame_bytes[5], frame_bytes[4]};
          frame.span_us      = {frame_bytes[7], frame_bytes[6]};
          frame.ground_dist  = {frame_bytes[9], frame_bytes[8]};
          frame.quality      = frame_bytes[10];
          frame.version_byte = frame_bytes[11];
          frames_due.push_back(frame);
          rx_phase = PH_IDLE;
        end else begin
          rx_pos++;
        end
      end
      default: rx_phase = PH_IDLE;
    endcase
  endtask

  // Offers one byte after a random idle stretch and waits for the transaction.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (!in_ready_o);
    parse_rx_byte(value);
  endtask

  // Sends a complete frame: header, ten body bytes, check byte and tail byte.
  task automatic send_frame(input logic [7:0] body [BodyLen], input logic [7:0] check_byte,
                            input logic [7:0] tail_byte);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    foreach (body[i]) send_byte(body[i]);
    send_byte(check_byte);
    send_byte(tail_byte);
  endtask

  function automatic logic [7:0] body_checksum(input logic [7:0] body [BodyLen]);
    logic [7:0] acc;
    acc = 8'h00;
    foreach (body[i]) acc = acc ^ body[i];
    return acc;
  endfunction

  // Compares one result transaction with the oldest pending frame.
  task automatic check_frame(input fsfr_result_t got);
    fsfr_result_t want;
    if (frames_due.size() == 0) begin
      report_mismatch("result with no frame pending");
      return;
    end
    want = frames_due.pop_front();
    if (got.checksum_ok !== want.checksum_ok)
      report_mismatch($sformatf("checksum_ok %0h, expected %0h", got.checksum_ok,
                                want.checksum_ok));
    if (got.flow_x_sum !== want.flow_x_sum)
      report_mismatch($sformatf("flow_x_sum %0h, expected %0h", got.flow_x_sum,
                                want.flow_x_sum));
    if (got.flow_y_sum !== want.flow_y_sum)
      report_mismatch($sformatf("flow_y_sum %0h, expected %0h", got.flow_y_sum,
                                want.flow_y_sum));
    if (got.span_us !== want.span_us)
      report_mismatch($sformatf("span_us %0h, expected %0h", got.span_us, want.span_us));
    if (got.ground_dist !== want.ground_dist)
      report_mismatch($sformatf("ground_dist %0h, expected %0h", got.ground_dist,
                                want.ground_dist));
    if (got.quality !== want.quality)
      report_mismatch($sformatf("quality %0h, expected %0h", got.quality, want.quality));
    if (got.version_byte !== want.version_byte)
      report_mismatch($sformatf("version_byte %0h, expected %0h", got.version_byte,
                                want.version_byte));
  endtask

  // Result side: checks each transaction and drives ready, with random stalls
  // and the long hold-off applied here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_frame({checksum_ok_o, flow_x_sum_o, flow_y_sum_o, span_us_o, ground_dist_o,
                   quality_o, version_byte_o});
    end
    if (hold_on) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles in which no transaction happens on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Header corner cases and frames with extreme field values.
  task automatic test_directed();
    logic [7:0] body [BodyLen];
    // Junk while hunting, a broken header, and a repeated first header byte.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HdrFirst);
    send_byte(8'h00);
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    // All-ones body with a matching check byte.
    foreach (body[i]) body[i] = 8'hFF;
    send_frame(body, body_checksum(body), 8'hFF);
    // All-zero body with a usable quality byte and a wrong check byte.
    foreach (body[i]) body[i] = 8'h00;
    body[8] = 8'hF5;
    send_frame(body, 8'hFF, 8'h00);
  endtask

  // Mostly well-formed frames with random content, mixed with junk and broken
  // headers.
  task automatic test_random_traffic(input int unsigned frame_count);
    logic [7:0] body [BodyLen];
    int unsigned frames_sent;
    int unsigned junk_len;
    frames_sent = 0;
    while (frames_sent < frame_count) begin
      if ($urandom_range(99) < 75) begin
        foreach (body[i]) begin
          case ($urandom_range(19))
            0:       body[i] = HdrFirst;
            1:       body[i] = HdrSecond;
            default: body[i] = 8'($urandom_range(255));
          endcase
        end
        if ($urandom_range(99) < 70) begin
          send_frame(body, body_checksum(body), 8'($urandom_range(255)));
        end else begin
          send_frame(body, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        frames_sent++;
      end else begin
        case ($urandom_range(2))
          0: begin
            junk_len = $urandom_range(4, 1);
            repeat (junk_len) send_byte(8'($urandom_range(255)));
          end
          1: begin
            send_byte(HdrFirst);
            send_byte(8'($urandom_range(255)));
          end
          default: begin
            send_byte(HdrFirst);
            send_byte(HdrFirst);
            send_byte(HdrSecond);
          end
        endcase
      end
    end
  endtask

  // Holds the receiver off while frames keep coming so the block fills up.
  // The hold-off is counted in a process of its own.
  task automatic test_backpressure();
    logic [7:0] body [BodyLen];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
      end
      begin
        repeat (3) begin
          foreach (body[i]) body[i] = 8'($urandom_range(255));
          send_frame(body, body_checksum(body), 8'($urandom_range(255)));
        end
      end
    join
  endtask

  initial begin
    rst_ni <= 1'b0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();

    sender_idle_pct = 0;  receiver_stall_pct = 0;
    test_random_traffic(11);
    sender_idle_pct = 87; receiver_stall_pct = 0;
    test_random_traffic(11);
    sender_idle_pct = 0;  receiver_stall_pct = 87;
    test_random_traffic(11);
    sender_idle_pct = 36; receiver_stall_pct = 36;
    test_random_traffic(11);

    test_backpressure();

    // Drain the outstanding frames, then allow for the output latency.
    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
